FILE: rtl/bbog_pkg.sv
// ---------------------------------------------------------------------------
// bbog_pkg
// Shared codes, field widths and defaults of the bounding box object grouper.
// ---------------------------------------------------------------------------
package bbog_pkg;

    // Default sizes of the top level parameters.
    localparam int DEF_MAX_OBJECTS = 32;
    localparam int DEF_COORD_BITS  = 24;
    localparam int DEF_COUNT_BITS  = 16;

    // Fixed widths of the result fields and registers.
    localparam int OBJ_IDX_W   = 5;
    localparam int GROUP_NUM_W = 6;
    localparam int LIMIT_W     = 8;
    localparam int CMD_W       = 2;
    localparam int REG_IDX_W   = 2;

    // Gap test scaling for Q16.8 coordinates: gap * 2^16 against limit * volume.
    localparam int GAP_SHIFT = 16;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SIZE_RATIO    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DENSITY_RATIO = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAP_RATIO     = 2'd2;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] SIZE_RATIO_RESET    = 8'd60;
    localparam logic [LIMIT_W-1:0] DENSITY_RATIO_RESET = 8'd18;
    localparam logic [LIMIT_W-1:0] GAP_RATIO_RESET     = 8'd5;

    // Result kinds.
    localparam logic KIND_MEMBER  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

FILE: rtl/bbog_ram.sv
// ---------------------------------------------------------------------------
// bbog_ram
// Simple dual port memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bbog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/bbog_mul.sv
// ---------------------------------------------------------------------------
// bbog_mul
// Shift and add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module bbog_mul #(
    parameter int PW = 112,
    parameter int MW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PW-1:0] a,
    input  logic [MW-1:0] m,
    output logic          done,
    output logic [PW-1:0] p
);

    logic          run_reg;
    logic [PW-1:0] a_reg;
    logic [MW-1:0] m_reg;
    logic [PW-1:0] acc_reg;

    // Run flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (run_reg && (m_reg == '0))
        begin
            run_reg <= 1'b0;
        end
    end

    // One partial product a cycle, low bit of the multiplier first.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (run_reg && (m_reg != '0))
        begin
            if (m_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            m_reg <= m_reg >> 1;
        end
    end

    assign done = run_reg && (m_reg == '0);
    assign p    = acc_reg;

endmodule

FILE: rtl/bbog_loader.sv
// ---------------------------------------------------------------------------
// bbog_loader
// Builds each object's box and vertex count and writes it to object memory.
// ---------------------------------------------------------------------------
module bbog_loader
    import bbog_pkg::*;
#(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    localparam int IDX_W      = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1,
    localparam int TOT_W      = $clog2(MAX_OBJECTS + 1),
    localparam int REC_W      = 6 * COORD_BITS + COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         scene_done,
    input  logic                         grp_done,
    output logic                         busy,
    output logic                         grp_start,
    output logic [TOT_W-1:0]             total,
    output logic                         overflow_seen,
    output logic                         wr_en,
    output logic [IDX_W-1:0]             wr_addr,
    output logic [REC_W-1:0]             wr_data
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                         open_reg, open_next;
    logic [TOT_W-1:0]             total_reg, total_next;
    logic                         ovf_reg, ovf_next;
    logic                         busy_reg, busy_next;
    logic                         start_reg, start_next;
    logic signed [COORD_BITS-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [COORD_BITS-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [COORD_BITS-1:0] min_x_next, min_y_next, min_z_next;
    logic signed [COORD_BITS-1:0] max_x_next, max_y_next, max_z_next;
    logic [COUNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [TOT_W-1:0]             t_total;

    // Request handling: open object box, object count and write to memory.
    always_comb
    begin
        open_next  = open_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        start_next = 1'b0;
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        min_z_next = min_z_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        max_z_next = max_z_reg;
        cnt_next   = cnt_reg;
        t_total    = total_reg;
        wr_en      = 1'b0;
        wr_addr    = total_reg[IDX_W-1:0];
        wr_data    = '0;
        if (grp_done)
        begin
            open_next  = 1'b0;
            total_next = '0;
            ovf_next   = 1'b0;
            busy_next  = 1'b0;
        end
        else if (accept)
        begin
            if ((command == CMD_VERTEX) || (command == CMD_CLOSE))
            begin
                if (!open_reg)
                begin
                    if (total_reg >= TOT_W'(MAX_OBJECTS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        min_x_next = coord_x;
                        min_y_next = coord_y;
                        min_z_next = coord_z;
                        max_x_next = coord_x;
                        max_y_next = coord_y;
                        max_z_next = coord_z;
                        cnt_next   = COUNT_BITS'(1);
                        open_next  = 1'b1;
                        wr_en      = 1'b1;
                    end
                end
                else
                begin
                    if (coord_x < min_x_reg) min_x_next = coord_x;
                    if (coord_x > max_x_reg) max_x_next = coord_x;
                    if (coord_y < min_y_reg) min_y_next = coord_y;
                    if (coord_y > max_y_reg) max_y_next = coord_y;
                    if (coord_z < min_z_reg) min_z_next = coord_z;
                    if (coord_z > max_z_reg) max_z_next = coord_z;
                    if (cnt_reg == CNT_MAX)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + COUNT_BITS'(1);
                    end
                    wr_en = 1'b1;
                end
                wr_data = {min_x_next, min_y_next, min_z_next,
                           max_x_next, max_y_next, max_z_next, cnt_next};
                if ((command == CMD_CLOSE) && open_next)
                begin
                    total_next = total_reg + TOT_W'(1);
                    open_next  = 1'b0;
                end
            end
            else if (command == CMD_EMPTY)
            begin
                // An open object is closed before the empty one is placed.
                t_total   = total_reg + TOT_W'(open_reg);
                open_next = 1'b0;
                if (t_total >= TOT_W'(MAX_OBJECTS))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = t_total[IDX_W-1:0];
                    wr_data = '0;
                    t_total = t_total + TOT_W'(1);
                end
                total_next = t_total;
            end
            if (scene_done)
            begin
                if (open_next)
                begin
                    total_next = total_next + TOT_W'(1);
                end
                open_next = 1'b0;
                if (total_next == '0)
                begin
                    ovf_next = 1'b0;
                end
                else
                begin
                    busy_next  = 1'b1;
                    start_next = 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
            start_reg <= start_next;
        end
    end

    // Open object box and count.
    always_ff @(posedge clk)
    begin
        min_x_reg <= min_x_next;
        min_y_reg <= min_y_next;
        min_z_reg <= min_z_next;
        max_x_reg <= max_x_next;
        max_y_reg <= max_y_next;
        max_z_reg <= max_z_next;
        cnt_reg   <= cnt_next;
    end

    assign busy          = busy_reg;
    assign grp_start     = start_reg;
    assign total         = total_reg;
    assign overflow_seen = ovf_reg;

endmodule

FILE: rtl/bbog_grouper.sv
// ---------------------------------------------------------------------------
// bbog_grouper
// Grouping sequencer: volumes, seed scan, candidate tests and result output.
// ---------------------------------------------------------------------------
module bbog_grouper
    import bbog_pkg::*;
#(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    localparam int IDX_W      = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1,
    localparam int TOT_W      = $clog2(MAX_OBJECTS + 1),
    localparam int REC_W      = 6 * COORD_BITS + COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [TOT_W-1:0]             total,
    input  logic                         overflow_seen,
    input  logic [LIMIT_W-1:0]           size_limit,
    input  logic [LIMIT_W-1:0]           density_limit,
    input  logic [LIMIT_W-1:0]           gap_limit,
    output logic                         busy,
    output logic                         done,
    output logic                         obj_rd_en,
    output logic [IDX_W-1:0]             obj_rd_addr,
    input  logic [REC_W-1:0]             obj_rd_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_kind,
    output logic [OBJ_IDX_W-1:0]         out_index,
    output logic [GROUP_NUM_W-1:0]       out_group,
    output logic [GROUP_NUM_W-1:0]       out_count,
    output logic signed [COORD_BITS-1:0] out_min_x,
    output logic signed [COORD_BITS-1:0] out_min_y,
    output logic signed [COORD_BITS-1:0] out_min_z,
    output logic signed [COORD_BITS-1:0] out_max_x,
    output logic signed [COORD_BITS-1:0] out_max_y,
    output logic signed [COORD_BITS-1:0] out_max_z,
    output logic                         out_overflow,
    output logic                         out_last
);

    localparam int VOL_W = 3 * COORD_BITS;
    localparam int PW    = VOL_W + LIMIT_W + 2 * COUNT_BITS;
    localparam int MW0   = (COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS;
    localparam int MW    = (MW0 > LIMIT_W) ? MW0 : LIMIT_W;
    localparam int GAP_W = COORD_BITS + 2;
    localparam int GRW   = TOT_W + VOL_W;

    // Sequencer states.
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_V_RD   = 5'd1;
    localparam logic [4:0] ST_V_WT   = 5'd2;
    localparam logic [4:0] ST_V_M1   = 5'd3;
    localparam logic [4:0] ST_V_M2   = 5'd4;
    localparam logic [4:0] ST_SC_RD  = 5'd5;
    localparam logic [4:0] ST_SC_WT  = 5'd6;
    localparam logic [4:0] ST_A_RD   = 5'd7;
    localparam logic [4:0] ST_A_WT   = 5'd8;
    localparam logic [4:0] ST_T1     = 5'd9;
    localparam logic [4:0] ST_T2     = 5'd10;
    localparam logic [4:0] ST_T3A    = 5'd11;
    localparam logic [4:0] ST_T3B    = 5'd12;
    localparam logic [4:0] ST_T3C    = 5'd13;
    localparam logic [4:0] ST_T4A    = 5'd14;
    localparam logic [4:0] ST_T4B    = 5'd15;
    localparam logic [4:0] ST_T4C    = 5'd16;
    localparam logic [4:0] ST_T5     = 5'd17;
    localparam logic [4:0] ST_A_NEXT = 5'd18;
    localparam logic [4:0] ST_O_RD   = 5'd19;
    localparam logic [4:0] ST_O_WT   = 5'd20;
    localparam logic [4:0] ST_O_EM   = 5'd21;
    localparam logic [4:0] ST_O_NEXT = 5'd22;
    localparam logic [4:0] ST_O_SUM  = 5'd23;
    localparam logic [4:0] ST_DONE   = 5'd24;

    logic [4:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             c_reg, s_reg, imax_reg;
    logic                         first_reg;
    logic [TOT_W-1:0]             g_reg, cnt_reg;
    logic [COUNT_BITS-1:0]        best_cnt_reg, ns_reg, nc_reg;
    logic [COORD_BITS-1:0]        dz_reg;
    logic [VOL_W-1:0]             vs_reg, vc_reg;
    logic [GAP_W-1:0]             gap_reg;
    logic [PW-1:0]                l_reg;
    logic signed [COORD_BITS-1:0] s_min_x, s_min_y, s_min_z;
    logic signed [COORD_BITS-1:0] s_max_x, s_max_y, s_max_z;
    logic signed [COORD_BITS-1:0] b_min_x, b_min_y, b_min_z;
    logic signed [COORD_BITS-1:0] b_max_x, b_max_y, b_max_z;
    logic                         out_valid_reg;

    // Memory read fields.
    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [COORD_BITS-1:0] r_max_x, r_max_y, r_max_z;
    logic [COUNT_BITS-1:0]        r_cnt;
    logic [GRW-1:0]               grp_rd_data;
    logic [TOT_W-1:0]             r_grp;
    logic [VOL_W-1:0]             r_vol;

    logic                         grp_wr_en;
    logic [IDX_W-1:0]             grp_wr_addr;
    logic [GRW-1:0]               grp_wr_data;
    logic [IDX_W-1:0]             seed_addr;
    logic                         c_last, s_last, slot_free, cand_skip, reject;
    logic                         match, load_member, load_summary;

    logic                         mul_start, mul_done;
    logic [PW-1:0]                mul_a, mul_p;
    logic [MW-1:0]                mul_m;

    logic signed [COORD_BITS:0]   dx_w, dy_w, dz_w;
    logic signed [COORD_BITS:0]   gxa, gxb, gya, gyb, gza, gzb;
    logic [COORD_BITS-1:0]        gx, gy, gz;
    logic [GAP_W-1:0]             gap_w;

    assign r_cnt   = obj_rd_data[COUNT_BITS-1:0];
    assign r_max_z = obj_rd_data[COUNT_BITS +: COORD_BITS];
    assign r_max_y = obj_rd_data[COUNT_BITS + COORD_BITS +: COORD_BITS];
    assign r_max_x = obj_rd_data[COUNT_BITS + 2 * COORD_BITS +: COORD_BITS];
    assign r_min_z = obj_rd_data[COUNT_BITS + 3 * COORD_BITS +: COORD_BITS];
    assign r_min_y = obj_rd_data[COUNT_BITS + 4 * COORD_BITS +: COORD_BITS];
    assign r_min_x = obj_rd_data[COUNT_BITS + 5 * COORD_BITS +: COORD_BITS];
    assign r_vol   = grp_rd_data[VOL_W-1:0];
    assign r_grp   = grp_rd_data[VOL_W +: TOT_W];

    // Group number and volume of every object.
    bbog_ram #(
        .WIDTH (GRW),
        .DEPTH (MAX_OBJECTS)
    ) u_grp_ram (
        .clk     (clk),
        .wr_en   (grp_wr_en),
        .wr_addr (grp_wr_addr),
        .wr_data (grp_wr_data),
        .rd_en   (obj_rd_en),
        .rd_addr (obj_rd_addr),
        .rd_data (grp_rd_data)
    );

    // Shared multiplier for volumes and ratio tests.
    bbog_mul #(
        .PW (PW),
        .MW (MW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .m     (mul_m),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Box extents of the object just read.
    assign dx_w = {r_max_x[COORD_BITS-1], r_max_x} - {r_min_x[COORD_BITS-1], r_min_x};
    assign dy_w = {r_max_y[COORD_BITS-1], r_max_y} - {r_min_y[COORD_BITS-1], r_min_y};
    assign dz_w = {r_max_z[COORD_BITS-1], r_max_z} - {r_min_z[COORD_BITS-1], r_min_z};

    // Summed axis offsets between the candidate read and the seed box.
    assign gxa = {s_max_x[COORD_BITS-1], s_max_x} - {r_min_x[COORD_BITS-1], r_min_x};
    assign gxb = {r_max_x[COORD_BITS-1], r_max_x} - {s_min_x[COORD_BITS-1], s_min_x};
    assign gya = {s_max_y[COORD_BITS-1], s_max_y} - {r_min_y[COORD_BITS-1], r_min_y};
    assign gyb = {r_max_y[COORD_BITS-1], r_max_y} - {s_min_y[COORD_BITS-1], s_min_y};
    assign gza = {s_max_z[COORD_BITS-1], s_max_z} - {r_min_z[COORD_BITS-1], r_min_z};
    assign gzb = {r_max_z[COORD_BITS-1], r_max_z} - {s_min_z[COORD_BITS-1], s_min_z};
    assign gx  = (r_min_x < s_max_x) ? gxa[COORD_BITS-1:0] :
                 (r_max_x > s_min_x) ? gxb[COORD_BITS-1:0] : '0;
    assign gy  = (r_min_y < s_max_y) ? gya[COORD_BITS-1:0] :
                 (r_max_y > s_min_y) ? gyb[COORD_BITS-1:0] : '0;
    assign gz  = (r_min_z < s_max_z) ? gza[COORD_BITS-1:0] :
                 (r_max_z > s_min_z) ? gzb[COORD_BITS-1:0] : '0;
    assign gap_w = GAP_W'(gx) + GAP_W'(gy) + GAP_W'(gz);

    assign seed_addr = first_reg ? imax_reg : s_reg;
    assign c_last    = (TOT_W'(c_reg) + TOT_W'(1)) == total;
    assign s_last    = (TOT_W'(s_reg) + TOT_W'(1)) == total;
    assign slot_free = !out_valid_reg || out_ready;
    assign cand_skip = (r_grp != '0) || (r_cnt == '0) || (r_vol == '0);
    assign match     = (r_grp == g_reg) && (r_cnt != '0);
    assign load_member  = (state_reg == ST_O_EM) && slot_free;
    assign load_summary = (state_reg == ST_O_SUM) && slot_free;

    // Reject condition of the test finishing in this state.
    always_comb
    begin
        case (state_reg)
            ST_T1:            reject = PW'(vc_reg) > mul_p;
            ST_T2:            reject = PW'(vs_reg) > mul_p;
            ST_T3C, ST_T4C:   reject = l_reg > mul_p;
            ST_T5:            reject = (PW'(gap_reg) << GAP_SHIFT) > mul_p;
            default:          reject = 1'b0;
        endcase
    end

    // Multiplier operands for each step.
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_m     = '0;
        unique case (state_reg)
            ST_V_WT:
            begin
                mul_start = 1'b1;
                mul_a     = PW'(dx_w[COORD_BITS-1:0]);
                mul_m     = MW'(dy_w[COORD_BITS-1:0]);
            end
            ST_V_M1:
            begin
                mul_start = mul_done;
                mul_a     = mul_p;
                mul_m     = MW'(dz_reg);
            end
            ST_A_WT:
            begin
                mul_start = !cand_skip;
                mul_a     = PW'(vs_reg);
                mul_m     = MW'(size_limit);
            end
            ST_T1:
            begin
                mul_start = mul_done && !reject;
                mul_a     = PW'(vc_reg);
                mul_m     = MW'(size_limit);
            end
            ST_T2:
            begin
                mul_start = mul_done && !reject;
                mul_a     = PW'(vc_reg);
                mul_m     = MW'(ns_reg);
            end
            ST_T3A:
            begin
                mul_start = mul_done;
                mul_a     = PW'(vs_reg);
                mul_m     = MW'(density_limit);
            end
            ST_T3B:
            begin
                mul_start = mul_done;
                mul_a     = mul_p;
                mul_m     = MW'(nc_reg);
            end
            ST_T3C:
            begin
                mul_start = mul_done && !reject;
                mul_a     = PW'(vs_reg);
                mul_m     = MW'(nc_reg);
            end
            ST_T4A:
            begin
                mul_start = mul_done;
                mul_a     = PW'(vc_reg);
                mul_m     = MW'(density_limit);
            end
            ST_T4B:
            begin
                mul_start = mul_done;
                mul_a     = mul_p;
                mul_m     = MW'(ns_reg);
            end
            ST_T4C:
            begin
                mul_start = mul_done && !reject;
                mul_a     = PW'(vc_reg);
                mul_m     = MW'(gap_limit);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Memory read requests.
    always_comb
    begin
        obj_rd_en   = 1'b0;
        obj_rd_addr = c_reg;
        case (state_reg)
            ST_V_RD, ST_A_RD, ST_O_RD:
            begin
                obj_rd_en = 1'b1;
            end
            ST_SC_RD:
            begin
                obj_rd_en   = 1'b1;
                obj_rd_addr = seed_addr;
            end
            default:
            begin
                obj_rd_en = 1'b0;
            end
        endcase
    end

    // Group memory writes: cleared group with volume, seed and absorbed member.
    always_comb
    begin
        grp_wr_en   = 1'b0;
        grp_wr_addr = c_reg;
        grp_wr_data = {TOT_W'(0), mul_p[VOL_W-1:0]};
        case (state_reg)
            ST_V_M2:
            begin
                grp_wr_en = mul_done;
            end
            ST_SC_WT:
            begin
                grp_wr_en   = first_reg || (r_grp == '0);
                grp_wr_addr = seed_addr;
                grp_wr_data = {g_reg + TOT_W'(1), r_vol};
            end
            ST_T5:
            begin
                grp_wr_en   = mul_done && !reject;
                grp_wr_data = {g_reg, vc_reg};
            end
            default:
            begin
                grp_wr_en = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_V_RD;
            ST_V_RD:   state_next = ST_V_WT;
            ST_V_WT:   state_next = ST_V_M1;
            ST_V_M1:   if (mul_done) state_next = ST_V_M2;
            ST_V_M2:
            begin
                if (mul_done)
                begin
                    state_next = c_last ? ST_SC_RD : ST_V_RD;
                end
            end
            ST_SC_RD:  state_next = ST_SC_WT;
            ST_SC_WT:
            begin
                if ((first_reg || (r_grp == '0)) && (r_cnt != '0))
                begin
                    state_next = ST_A_RD;
                end
                else if (!first_reg && s_last)
                begin
                    state_next = ST_O_RD;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_A_RD:   state_next = ST_A_WT;
            ST_A_WT:   state_next = cand_skip ? ST_A_NEXT : ST_T1;
            ST_T1, ST_T2, ST_T3C, ST_T4C:
            begin
                if (mul_done)
                begin
                    state_next = reject ? ST_A_NEXT : state_reg + 5'd1;
                end
            end
            ST_T3A, ST_T3B, ST_T4A, ST_T4B:
            begin
                if (mul_done) state_next = state_reg + 5'd1;
            end
            ST_T5:     if (mul_done) state_next = ST_A_NEXT;
            ST_A_NEXT:
            begin
                if (!c_last)
                begin
                    state_next = ST_A_RD;
                end
                else if (!first_reg && s_last)
                begin
                    state_next = ST_O_RD;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_O_RD:   state_next = ST_O_WT;
            ST_O_WT:   state_next = match ? ST_O_EM : ST_O_NEXT;
            ST_O_EM:   if (slot_free) state_next = ST_O_NEXT;
            ST_O_NEXT: state_next = c_last ? ST_O_SUM : ST_O_RD;
            ST_O_SUM:
            begin
                if (slot_free)
                begin
                    state_next = (g_reg == TOT_W'(1)) ? ST_DONE : ST_O_RD;
                end
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_member || load_summary)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sequencer counters, seed and candidate data.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                c_reg        <= '0;
                imax_reg     <= '0;
                best_cnt_reg <= '0;
            end
            ST_V_WT:
            begin
                dz_reg <= dz_w[COORD_BITS-1:0];
                if (r_cnt > best_cnt_reg)
                begin
                    best_cnt_reg <= r_cnt;
                    imax_reg     <= c_reg;
                end
            end
            ST_V_M2:
            begin
                if (mul_done)
                begin
                    if (c_last)
                    begin
                        first_reg <= 1'b1;
                        s_reg     <= '0;
                        g_reg     <= '0;
                    end
                    else
                    begin
                        c_reg <= c_reg + IDX_W'(1);
                    end
                end
            end
            ST_SC_WT:
            begin
                if (first_reg || (r_grp == '0))
                begin
                    g_reg   <= g_reg + TOT_W'(1);
                    s_min_x <= r_min_x;
                    s_min_y <= r_min_y;
                    s_min_z <= r_min_z;
                    s_max_x <= r_max_x;
                    s_max_y <= r_max_y;
                    s_max_z <= r_max_z;
                    ns_reg  <= r_cnt;
                    vs_reg  <= r_vol;
                end
                c_reg   <= '0;
                cnt_reg <= '0;
                b_min_x <= '0;
                b_min_y <= '0;
                b_min_z <= '0;
                b_max_x <= '0;
                b_max_y <= '0;
                b_max_z <= '0;
                // Move the scan on unless an absorb pass follows.
                if (!((first_reg || (r_grp == '0)) && (r_cnt != '0)))
                begin
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                    end
                    else if (!s_last)
                    begin
                        s_reg <= s_reg + IDX_W'(1);
                    end
                end
            end
            ST_A_WT:
            begin
                nc_reg  <= r_cnt;
                vc_reg  <= r_vol;
                gap_reg <= gap_w;
            end
            ST_T3A, ST_T4A:
            begin
                if (mul_done)
                begin
                    l_reg <= mul_p;
                end
            end
            ST_A_NEXT:
            begin
                if (!c_last)
                begin
                    c_reg <= c_reg + IDX_W'(1);
                end
                else
                begin
                    c_reg <= '0;
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                    end
                    else if (!s_last)
                    begin
                        s_reg <= s_reg + IDX_W'(1);
                    end
                end
            end
            ST_O_WT:
            begin
                // Merge a non-empty member into the group box.
                if (match)
                begin
                    if ((cnt_reg == '0) || (r_min_x < b_min_x)) b_min_x <= r_min_x;
                    if ((cnt_reg == '0) || (r_min_y < b_min_y)) b_min_y <= r_min_y;
                    if ((cnt_reg == '0) || (r_min_z < b_min_z)) b_min_z <= r_min_z;
                    if ((cnt_reg == '0) || (r_max_x > b_max_x)) b_max_x <= r_max_x;
                    if ((cnt_reg == '0) || (r_max_y > b_max_y)) b_max_y <= r_max_y;
                    if ((cnt_reg == '0) || (r_max_z > b_max_z)) b_max_z <= r_max_z;
                    cnt_reg <= cnt_reg + TOT_W'(1);
                end
            end
            ST_O_NEXT:
            begin
                if (!c_last)
                begin
                    c_reg <= c_reg + IDX_W'(1);
                end
            end
            ST_O_SUM:
            begin
                if (slot_free)
                begin
                    g_reg   <= g_reg - TOT_W'(1);
                    c_reg   <= '0;
                    cnt_reg <= '0;
                    b_min_x <= '0;
                    b_min_y <= '0;
                    b_min_z <= '0;
                    b_max_x <= '0;
                    b_max_y <= '0;
                    b_max_z <= '0;
                end
            end
            default:
            begin
                l_reg <= l_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_member)
        begin
            out_kind     <= KIND_MEMBER;
            out_index    <= OBJ_IDX_W'(c_reg);
            out_group    <= GROUP_NUM_W'(g_reg);
            out_count    <= '0;
            out_min_x    <= '0;
            out_min_y    <= '0;
            out_min_z    <= '0;
            out_max_x    <= '0;
            out_max_y    <= '0;
            out_max_z    <= '0;
            out_overflow <= overflow_seen;
            out_last     <= 1'b0;
        end
        else if (load_summary)
        begin
            out_kind     <= KIND_SUMMARY;
            out_index    <= '0;
            out_group    <= GROUP_NUM_W'(g_reg);
            out_count    <= GROUP_NUM_W'(cnt_reg);
            out_min_x    <= b_min_x;
            out_min_y    <= b_min_y;
            out_min_z    <= b_min_z;
            out_max_x    <= b_max_x;
            out_max_y    <= b_max_y;
            out_max_z    <= b_max_z;
            out_overflow <= overflow_seen;
            out_last     <= (g_reg == TOT_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign busy      = state_reg != ST_IDLE;
    assign done      = state_reg == ST_DONE;

endmodule

FILE: rtl/bounding_box_object_grouper.sv
// ---------------------------------------------------------------------------
// bounding_box_object_grouper
// Collects object bounding boxes from a vertex stream and groups the objects.
// ---------------------------------------------------------------------------
// Usage: each input request carries one command (vertex, vertex that closes
// the object, empty object, or no action), a vertex position and scene_done.
// While loading, in_ready stays high and one request is taken every cycle;
// the open object's box is kept in registers and written to object memory.
// A request with scene_done closes the open object and, if any object
// exists, starts grouping; in_ready then stays low until the whole result
// list has been handed to the output register. Grouping first reads every
// object once for its volume, then each seed walks all objects, and each
// tested candidate runs its size, density and gap tests one after another
// on the shared shift-and-add multiplier, which sets the grouping time.
// Results leave through one output register; when out_ready is low the
// sequencer waits and nothing is lost. Reset clears the scene and sets the
// ratio limits to 60, 18 and 5. Configuration writes take effect at once.
// ---------------------------------------------------------------------------
module bounding_box_object_grouper
    import bbog_pkg::*;
#(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [REG_IDX_W-1:0]         cfg_index,
    input  logic [LIMIT_W-1:0]           cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         scene_done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [OBJ_IDX_W-1:0]         object_index,
    output logic [GROUP_NUM_W-1:0]       group_number,
    output logic [GROUP_NUM_W-1:0]       member_count,
    output logic signed [COORD_BITS-1:0] box_min_x,
    output logic signed [COORD_BITS-1:0] box_min_y,
    output logic signed [COORD_BITS-1:0] box_min_z,
    output logic signed [COORD_BITS-1:0] box_max_x,
    output logic signed [COORD_BITS-1:0] box_max_y,
    output logic signed [COORD_BITS-1:0] box_max_z,
    output logic                         overflow,
    output logic                         last
);

    localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int TOT_W = $clog2(MAX_OBJECTS + 1);
    localparam int REC_W = 6 * COORD_BITS + COUNT_BITS;

    logic [LIMIT_W-1:0] size_limit_reg, density_limit_reg, gap_limit_reg;
    logic               in_accept, load_busy, grp_start, grp_busy, grp_done;
    logic [TOT_W-1:0]   total;
    logic               overflow_seen;
    logic               obj_wr_en, obj_rd_en;
    logic [IDX_W-1:0]   obj_wr_addr, obj_rd_addr;
    logic [REC_W-1:0]   obj_wr_data, obj_rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg    <= SIZE_RATIO_RESET;
            density_limit_reg <= DENSITY_RATIO_RESET;
            gap_limit_reg     <= GAP_RATIO_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SIZE_RATIO:    size_limit_reg    <= cfg_data;
                REG_DENSITY_RATIO: density_limit_reg <= cfg_data;
                REG_GAP_RATIO:     gap_limit_reg     <= cfg_data;
                default:           size_limit_reg    <= size_limit_reg;
            endcase
        end
    end

    // Input requests are taken only while no scene is being grouped.
    assign in_ready  = !load_busy;
    assign in_accept = in_valid && in_ready;

    bbog_loader #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_loader (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .command       (command),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .scene_done    (scene_done),
        .grp_done      (grp_done),
        .busy          (load_busy),
        .grp_start     (grp_start),
        .total         (total),
        .overflow_seen (overflow_seen),
        .wr_en         (obj_wr_en),
        .wr_addr       (obj_wr_addr),
        .wr_data       (obj_wr_data)
    );

    // Object boxes and vertex counts.
    bbog_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_OBJECTS)
    ) u_obj_ram (
        .clk     (clk),
        .wr_en   (obj_wr_en),
        .wr_addr (obj_wr_addr),
        .wr_data (obj_wr_data),
        .rd_en   (obj_rd_en),
        .rd_addr (obj_rd_addr),
        .rd_data (obj_rd_data)
    );

    bbog_grouper #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_grouper (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (grp_start),
        .total         (total),
        .overflow_seen (overflow_seen),
        .size_limit    (size_limit_reg),
        .density_limit (density_limit_reg),
        .gap_limit     (gap_limit_reg),
        .busy          (grp_busy),
        .done          (grp_done),
        .obj_rd_en     (obj_rd_en),
        .obj_rd_addr   (obj_rd_addr),
        .obj_rd_data   (obj_rd_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (kind),
        .out_index     (object_index),
        .out_group     (group_number),
        .out_count     (member_count),
        .out_min_x     (box_min_x),
        .out_min_y     (box_min_y),
        .out_min_z     (box_min_z),
        .out_max_x     (box_max_x),
        .out_max_y     (box_max_y),
        .out_max_z     (box_max_z),
        .out_overflow  (overflow),
        .out_last      (last)
    );

    // Grouping starts only with at least one object stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_start |-> (total != '0))
        else $error("grouping started on an empty scene");

    // Object memory is never written while the grouper reads it.
    assert property (@(posedge clk) disable iff (!rst_n)
        obj_wr_en |-> !grp_busy)
        else $error("object memory written during grouping");

    // A result only appears while grouping runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(grp_busy))
        else $error("result produced outside grouping");

endmodule

FILE: tb/bbog_scene_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bbog_scene_checker
// Watches the request, result and register ports of the object grouper,
// rebuilds each scene's object boxes, groups them on scene_done and compares
// every delivered result with the oldest predicted one.
// ---------------------------------------------------------------------------
module bbog_scene_checker
    import bbog_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [REG_IDX_W-1:0]   cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [CMD_W-1:0]       command,
    input  logic signed [23:0]     coord_x,
    input  logic signed [23:0]     coord_y,
    input  logic signed [23:0]     coord_z,
    input  logic                   scene_done,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   kind,
    input  logic [OBJ_IDX_W-1:0]   object_index,
    input  logic [GROUP_NUM_W-1:0] group_number,
    input  logic [GROUP_NUM_W-1:0] member_count,
    input  logic signed [23:0]     box_min_x,
    input  logic signed [23:0]     box_min_y,
    input  logic signed [23:0]     box_min_z,
    input  logic signed [23:0]     box_max_x,
    input  logic signed [23:0]     box_max_y,
    input  logic signed [23:0]     box_max_z,
    input  logic                   overflow,
    input  logic                   last,
    output int                     fail_count,
    output int                     pending,
    output int                     results_seen
);

    localparam int NOBJ      = DEF_MAX_OBJECTS;
    localparam int COUNT_MAX = (1 << DEF_COUNT_BITS) - 1;

    typedef struct packed {
        logic                   kind;
        logic [OBJ_IDX_W-1:0]   obj;
        logic [GROUP_NUM_W-1:0] grp;
        logic [GROUP_NUM_W-1:0] cnt;
        logic [5:0][23:0]       box;
        logic                   ovf;
        logic                   fin;
    } group_result_t;

    // Scene state: box per object as min x/y/z then max x/y/z.
    int            obj_box [NOBJ][6];
    int            obj_verts [NOBJ];
    int            obj_grp [NOBJ];
    logic [127:0]  obj_vol [NOBJ];
    int            obj_total;
    logic          obj_open;
    logic          scene_ovf;
    int            lim_size;
    int            lim_density;
    int            lim_gap;
    group_result_t expected_q[$];

    // True when a*ma exceeds b*mb*mc.
    function automatic logic ratio_over(logic [127:0] a, int ma, logic [127:0] b,
                                        int mb, int mc);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = a * 128'(ma);
        rhs = b * 128'(mb) * 128'(mc);
        return lhs > rhs;
    endfunction

    task automatic clear_scene();
        for (int i = 0; i < NOBJ; i++)
        begin
            obj_grp[i] = 0;
            obj_verts[i] = 0;
            for (int j = 0; j < 6; j++)
                obj_box[i][j] = 0;
        end
        obj_total = 0;
        obj_open = 1'b0;
        scene_ovf = 1'b0;
    endtask

    task automatic close_open();
        if (obj_open)
        begin
            obj_total++;
            obj_open = 1'b0;
        end
    endtask

    task automatic take_vertex(int x, int y, int z);
        int k;
        int p[3];
        k = obj_total;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        if (!obj_open)
        begin
            if (obj_total >= NOBJ)
                scene_ovf = 1'b1;
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    obj_box[k][a] = p[a];
                    obj_box[k][a+3] = p[a];
                end
                obj_verts[k] = 1;
                obj_open = 1'b1;
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
                if (p[a] < obj_box[k][a])
                    obj_box[k][a] = p[a];
                else if (p[a] > obj_box[k][a+3])
                    obj_box[k][a+3] = p[a];
            if (obj_verts[k] >= COUNT_MAX)
                scene_ovf = 1'b1;
            else
                obj_verts[k]++;
        end
    endtask

    task automatic take_empty();
        close_open();
        if (obj_total >= NOBJ)
            scene_ovf = 1'b1;
        else
        begin
            for (int j = 0; j < 6; j++)
                obj_box[obj_total][j] = 0;
            obj_verts[obj_total] = 0;
            obj_total++;
        end
    endtask

    // A non-empty seed pulls in every ungrouped object that passes all tests.
    task automatic absorb_into(int s);
        longint       gap;
        logic [127:0] gw;
        logic [127:0] vg;
        int           ns;
        int           nc;
        ns = obj_verts[s];
        if (ns == 0)
            return;
        for (int i = 0; i < obj_total; i++)
        begin
            nc = obj_verts[i];
            if (obj_grp[i] != 0 || nc == 0 || obj_vol[i] == 0)
                continue;
            if (ratio_over(obj_vol[i], 1, obj_vol[s], lim_size, 1))
                continue;
            if (ratio_over(obj_vol[s], 1, obj_vol[i], lim_size, 1))
                continue;
            if (ratio_over(obj_vol[i], ns, obj_vol[s], lim_density, nc))
                continue;
            if (ratio_over(obj_vol[s], nc, obj_vol[i], lim_density, ns))
                continue;
            gap = 0;
            for (int a = 0; a < 3; a++)
                if (obj_box[i][a] < obj_box[s][a+3])
                    gap += longint'(obj_box[s][a+3]) - longint'(obj_box[i][a]);
                else if (obj_box[i][a+3] > obj_box[s][a])
                    gap += longint'(obj_box[i][a+3]) - longint'(obj_box[s][a]);
            gw = 128'(gap) << GAP_SHIFT;
            vg = obj_vol[i] * 128'(lim_gap);
            if (gw > vg)
                continue;
            obj_grp[i] = obj_grp[s];
        end
    endtask

    task automatic group_scene();
        int            imax;
        int            g;
        int            cnt;
        logic [127:0]  v;
        group_result_t r;
        if (obj_total == 0)
            return;
        imax = 0;
        for (int i = 0; i < obj_total; i++)
        begin
            obj_grp[i] = 0;
            v = 128'(obj_box[i][3] - obj_box[i][0]);
            v = v * 128'(obj_box[i][4] - obj_box[i][1]);
            obj_vol[i] = v * 128'(obj_box[i][5] - obj_box[i][2]);
            if (obj_verts[i] > obj_verts[imax])
                imax = i;
        end
        g = 1;
        obj_grp[imax] = 1;
        absorb_into(imax);
        for (int i = 0; i < obj_total; i++)
            if (obj_grp[i] == 0)
            begin
                g++;
                obj_grp[i] = g;
                absorb_into(i);
            end
        // Groups are reported from the highest number down.
        for (; g > 0; g--)
        begin
            int gbox[6];
            cnt = 0;
            for (int j = 0; j < 6; j++)
                gbox[j] = 0;
            for (int i = 0; i < obj_total; i++)
            begin
                if (obj_grp[i] != g || obj_verts[i] == 0)
                    continue;
                for (int a = 0; a < 3; a++)
                begin
                    if (cnt == 0 || obj_box[i][a] < gbox[a])
                        gbox[a] = obj_box[i][a];
                    if (cnt == 0 || obj_box[i][a+3] > gbox[a+3])
                        gbox[a+3] = obj_box[i][a+3];
                end
                cnt++;
                r = '0;
                r.kind = KIND_MEMBER;
                r.obj = OBJ_IDX_W'(i);
                r.grp = GROUP_NUM_W'(g);
                r.ovf = scene_ovf;
                expected_q.push_back(r);
            end
            r = '0;
            r.kind = KIND_SUMMARY;
            r.grp = GROUP_NUM_W'(g);
            r.cnt = GROUP_NUM_W'(cnt);
            for (int j = 0; j < 6; j++)
                r.box[j] = gbox[j][23:0];
            r.ovf = scene_ovf;
            expected_q.push_back(r);
        end
        r = expected_q.pop_back();
        r.fin = 1'b1;
        expected_q.push_back(r);
    endtask

    // Track registers, requests and results at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        group_result_t got;
        group_result_t want;
        if (!rst_n)
        begin
            lim_size = SIZE_RATIO_RESET;
            lim_density = DENSITY_RATIO_RESET;
            lim_gap = GAP_RATIO_RESET;
            clear_scene();
            expected_q.delete();
            fail_count = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_SIZE_RATIO:    lim_size = cfg_data;
                    REG_DENSITY_RATIO: lim_density = cfg_data;
                    REG_GAP_RATIO:     lim_gap = cfg_data;
                    default:           ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got.kind = kind;
                got.obj = object_index;
                got.grp = group_number;
                got.cnt = member_count;
                got.box = {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x};
                got.ovf = overflow;
                got.fin = last;
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result kind=%0d group=%0d",
                                 got.kind, got.grp);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind != want.kind || got.obj != want.obj ||
                        got.grp != want.grp || got.cnt != want.cnt ||
                        got.box != want.box || got.ovf != want.ovf ||
                        got.fin != want.fin)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("ERROR: result %0d mismatch", results_seen);
                            $display("  expected kind=%0d obj=%0d grp=%0d cnt=%0d ovf=%0d last=%0d box=%h",
                                     want.kind, want.obj, want.grp, want.cnt,
                                     want.ovf, want.fin, want.box);
                            $display("  actual   kind=%0d obj=%0d grp=%0d cnt=%0d ovf=%0d last=%0d box=%h",
                                     got.kind, got.obj, got.grp, got.cnt,
                                     got.ovf, got.fin, got.box);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (command == CMD_VERTEX || command == CMD_CLOSE)
                begin
                    take_vertex(coord_x, coord_y, coord_z);
                    if (command == CMD_CLOSE)
                        close_open();
                end
                else if (command == CMD_EMPTY)
                    take_empty();
                if (scene_done)
                begin
                    close_open();
                    group_scene();
                    clear_scene();
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/bounding_box_object_grouper_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bounding_box_object_grouper_test
// Drives scenes of vertices into the object grouper: directed corner scenes,
// capacity overflow, then random clustered scenes under several ratio limit
// settings, with bursty requests and a stalling result side.
// ---------------------------------------------------------------------------
module bounding_box_object_grouper_test;
    import bbog_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [REG_IDX_W-1:0]   cfg_index = '0;
    logic [LIMIT_W-1:0]     cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CMD_W-1:0]       command = CMD_NOP;
    logic signed [23:0]     coord_x = '0;
    logic signed [23:0]     coord_y = '0;
    logic signed [23:0]     coord_z = '0;
    logic                   scene_done = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   kind;
    logic [OBJ_IDX_W-1:0]   object_index;
    logic [GROUP_NUM_W-1:0] group_number;
    logic [GROUP_NUM_W-1:0] member_count;
    logic signed [23:0]     box_min_x, box_min_y, box_min_z;
    logic signed [23:0]     box_max_x, box_max_y, box_max_z;
    logic                   overflow;
    logic                   last;
    int                     fail_count;
    int                     pending;
    int                     results_seen;
    int                     cycle_count = 0;
    int                     burst_left = 0;
    int                     items_sent = 0;
    int                     scenes_sent = 0;

    bounding_box_object_grouper uut (.*);

    bbog_scene_checker checker_i (.*);

    // Clock: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side alternates free flow with random stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[9])
            out_ready <= ($urandom_range(0, 3) != 0);
        else if (cycle_count[8])
            out_ready <= ($urandom_range(0, 15) > 12);
        else
            out_ready <= 1'b1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Send one request, with bursts separated by random gaps.
    task automatic send(logic [CMD_W-1:0] cmd, int x, int y, int z, logic done);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        command <= cmd;
        coord_x <= x[23:0];
        coord_y <= y[23:0];
        coord_z <= z[23:0];
        scene_done <= done;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (cmd != CMD_NOP)
            items_sent++;
        if (done)
            scenes_sent++;
    endtask

    // Hold requests back until every predicted result has been delivered.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Register writes happen only after a drain.
    task automatic set_limits(int s, int d, int g);
        drain();
        cfg_write_en <= 1'b1;
        cfg_index <= REG_SIZE_RATIO;
        cfg_data <= s[7:0];
        @(posedge clk);
        cfg_index <= REG_DENSITY_RATIO;
        cfg_data <= d[7:0];
        @(posedge clk);
        cfg_index <= REG_GAP_RATIO;
        cfg_data <= g[7:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // One object near a center, closed by its last vertex unless left open.
    task automatic cluster_object(int cx, int cy, int cz, int ext, int nv,
                                  bit closed, bit done);
        logic [CMD_W-1:0] cmd;
        for (int v = 0; v < nv; v++)
        begin
            cmd = (v == nv - 1 && closed) ? CMD_CLOSE : CMD_VERTEX;
            send(cmd, cx + $signed($urandom_range(0, 2 * ext)) - ext,
                 cy + $signed($urandom_range(0, 2 * ext)) - ext,
                 cz + $signed($urandom_range(0, 2 * ext)) - ext,
                 done && v == nv - 1);
        end
    endtask

    task automatic random_scene();
        int  nobj;
        int  cx, cy, cz, ext, sel;
        bit  end_on_object;
        nobj = $urandom_range(1, 7);
        cx = $signed($urandom_range(0, 8000)) - 4000;
        cy = $signed($urandom_range(0, 8000)) - 4000;
        cz = $signed($urandom_range(0, 8000)) - 4000;
        ext = $urandom_range(64, 3000);
        end_on_object = $urandom_range(0, 1);
        for (int o = 0; o < nobj; o++)
        begin
            sel = $urandom_range(0, 11);
            if (sel < 8)
                cluster_object(cx, cy, cz, ext + $urandom_range(0, ext),
                               $urandom_range(1, 6), sel != 7,
                               end_on_object && o == nobj - 1);
            else if (sel == 8)
                send(CMD_EMPTY, 0, 0, 0, end_on_object && o == nobj - 1);
            else if (sel == 9)
                cluster_object(0, 0, 0, 8388607, $urandom_range(1, 3), 1'b1,
                               end_on_object && o == nobj - 1);
            else
            begin
                // Wrong command noise and a tiny outlier box.
                send(CMD_NOP, $urandom, $urandom, $urandom, 1'b0);
                cluster_object(cx, cy, cz, $urandom_range(0, 8), $urandom_range(1, 4),
                               1'b1, end_on_object && o == nobj - 1);
            end
        end
        if (!end_on_object)
            send(CMD_NOP, $urandom, $urandom, $urandom, 1'b1);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coordinate extremes, empty objects, no-action items, closing on scene end.
        send(CMD_VERTEX, -8388608, -8388608, -8388608, 1'b0);
        send(CMD_CLOSE, 8388607, 8388607, 8388607, 1'b0);
        send(CMD_EMPTY, 0, 0, 0, 1'b0);
        send(CMD_NOP, -1, -1, -1, 1'b0);
        send(CMD_VERTEX, 100, 200, 300, 1'b0);
        send(CMD_EMPTY, 0, 0, 0, 1'b0);
        send(CMD_VERTEX, -500, 400, 0, 1'b0);
        send(CMD_VERTEX, 500, -400, 900, 1'b1);
        // A scene with no objects gives no results.
        send(CMD_NOP, 0, 0, 0, 1'b1);
        // Tie on vertex count and near-identical boxes that should merge.
        cluster_object(1000, 1000, 1000, 600, 3, 1'b1, 1'b0);
        cluster_object(1100, 900, 1050, 600, 3, 1'b1, 1'b0);
        cluster_object(1200, 1000, 900, 600, 2, 1'b1, 1'b0);
        send(CMD_EMPTY, 0, 0, 0, 1'b1);
        drain();

        // Capacity: more objects than the store holds, then a dropped vertex.
        for (int i = 0; i < DEF_MAX_OBJECTS + 2; i++)
            send(CMD_EMPTY, 0, 0, 0, 1'b0);
        send(CMD_CLOSE, 5, 5, 5, 1'b1);
        drain();

        // Random scenes under several limit settings.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:       set_limits(1, 1, 1);
                2:       set_limits(255, 255, 255);
                3:       set_limits($urandom_range(1, 255), $urandom_range(1, 255),
                                    $urandom_range(1, 255));
                4:       set_limits(2, 4, 1);
                5:       set_limits(60, 18, 5);
                default: ;
            endcase
            for (int s = 0; s < 5; s++)
            begin
                random_scene();
                if (s == 2)
                    drain();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        $display("Sent %0d scenes (%0d vertex and object requests) over %0d cycles;",
                 scenes_sent, items_sent, cycle_count);
        $display("checked %0d results, including capacity overflow and corner scenes.",
                 results_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
